FILE: hw/rtl/sstq_pkg.sv
// Shared types and constants for the sorted sleep timer queue.
`default_nettype none

package sstq_pkg;

	localparam int WAKE_W       = 32;
	localparam int ID_W         = 6;
	localparam int PERIOD_W     = 10;
	localparam int DEFAULT_DEPTH = 64;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_INS,
		ST_TICK
	} state_t;

	localparam logic MODE_SLEEP = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef struct packed {
		logic [WAKE_W-1:0] wake;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_sleep_timer_queue_core.sv
// Top level of the sorted sleep timer queue.
// Usage:
//   The input channel (in_valid/in_ready) carries one request per transfer:
//   mode 0 puts task_id to sleep for duration_ms, mode 1 checks now_tick and
//   wakes every due task. Results leave on the out_valid/out_ready channel.
//   A sleep request gives one result once the 32-step bit-serial divider
//   has finished, the current tick has been added and the entry inserted
//   into the cell chain; the result waits for a free output register. The
//   next request is taken once the block is back in idle.
//   A tick check gives one result per woken task, one per cycle while the
//   receiver takes them; each head pop shifts the whole chain left by one
//   cell. With nothing due it gives a single result with wake_valid low.
//   in_ready is high only while no request is in flight; a finished result
//   may still sit in the output register while the next request is taken.
//   A stalled receiver holds the output register and pauses pops.
//   Reset empties the queue and sets tick_period_ms to 10; no clearing pass.
//   cfg_we writes tick_period_ms from cfg_wdata; the user keeps it to idle.
`default_nettype none

module sorted_sleep_timer_queue_core #(
	parameter int QUEUE_DEPTH = sstq_pkg::DEFAULT_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sstq_pkg::PERIOD_W-1:0]   cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            mode,
	input  wire logic [sstq_pkg::ID_W-1:0]       task_id,
	input  wire logic [sstq_pkg::WAKE_W-1:0]     duration_ms,
	input  wire logic [sstq_pkg::WAKE_W-1:0]     now_tick,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [sstq_pkg::ID_W-1:0]            woken_task,
	output logic                                 wake_valid,
	output logic [sstq_pkg::WAKE_W-1:0]          wake_tick,
	output logic                                 queue_full,
	output logic                                 last
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
	localparam logic [sstq_pkg::PERIOD_W-1:0] ONE_PERIOD = sstq_pkg::PERIOD_W'(1);
	localparam logic [sstq_pkg::WAKE_W-1:0]   WAKE_ONE   = sstq_pkg::WAKE_W'(1);

	sstq_pkg::state_t                state_q, state_d;
	logic [sstq_pkg::PERIOD_W-1:0]   period_q;
	logic [CNT_W-1:0]                count_q;

	logic [sstq_pkg::ID_W-1:0]       id_q;
	logic [sstq_pkg::WAKE_W-1:0]     now_q;
	logic [sstq_pkg::WAKE_W-1:0]     wake_q;

	logic                            div_start;
	logic                            div_done;
	logic [sstq_pkg::WAKE_W-1:0]     div_quo;
	logic [sstq_pkg::PERIOD_W-1:0]   divisor;
	logic [sstq_pkg::WAKE_W-1:0]     ticks;

	sstq_pkg::cell_ctrl_t            ctrl;
	sstq_pkg::entry_t                new_entry;
	sstq_pkg::entry_t                cells  [QUEUE_DEPTH];
	logic                            gts    [QUEUE_DEPTH];

	logic                            full;
	logic                            out_free;
	logic                            head_due;
	logic                            next_due;
	logic                            in_xfer;

	logic                            out_load;
	logic [sstq_pkg::ID_W-1:0]       res_task;
	logic                            res_valid;
	logic [sstq_pkg::WAKE_W-1:0]     res_tick;
	logic                            res_full;
	logic                            res_last;

	logic                            out_valid_q;
	logic [sstq_pkg::ID_W-1:0]       woken_task_q;
	logic                            wake_valid_q;
	logic [sstq_pkg::WAKE_W-1:0]     wake_tick_q;
	logic                            queue_full_q;
	logic                            last_q;

	assign in_xfer   = in_valid && in_ready;
	assign full      = count_q == DEPTH_C;
	assign out_free  = !out_valid_q || out_ready;
	assign head_due  = (count_q != '0) && (cells[0].wake <= now_q);
	assign divisor   = (period_q == '0) ? ONE_PERIOD : period_q;
	assign ticks     = (div_quo == '0) ? WAKE_ONE : div_quo;
	assign new_entry = '{wake: wake_q, id: id_q};

	generate
		if (QUEUE_DEPTH > 1) begin : g_next
			assign next_due = (count_q > ONE_C) && (cells[1].wake <= now_q);
		end else begin : g_no_next
			assign next_due = 1'b0;
		end
	endgenerate

	// the divider loads at the transfer edge, so it takes the duration from the port
	sstq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (duration_ms),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	generate
		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			sstq_pkg::entry_t left_e;
			sstq_pkg::entry_t right_e;
			logic             left_g;
			if (i == 0) begin : g_first
				assign left_e = new_entry;
				assign left_g = 1'b0;
			end else begin : g_mid
				assign left_e = cells[i-1];
				assign left_g = gts[i-1];
			end
			if (i == QUEUE_DEPTH - 1) begin : g_end
				assign right_e = cells[i];
			end else begin : g_inner
				assign right_e = cells[i+1];
			end
			sstq_cell #(
				.IDX   (i),
				.DEPTH (QUEUE_DEPTH)
			) u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.count       (count_q),
				.new_entry   (new_entry),
				.left_entry  (left_e),
				.left_gt     (left_g),
				.right_entry (right_e),
				.entry       (cells[i]),
				.gt          (gts[i])
			);
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sstq_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = (mode == sstq_pkg::MODE_SLEEP) ? sstq_pkg::ST_DIV
					                                         : sstq_pkg::ST_TICK;
				end
			end
			sstq_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = sstq_pkg::ST_INS;
				end
			end
			sstq_pkg::ST_INS: begin
				if (out_free) begin
					state_d = sstq_pkg::ST_IDLE;
				end
			end
			sstq_pkg::ST_TICK: begin
				if (out_free && !(head_due && next_due)) begin
					state_d = sstq_pkg::ST_IDLE;
				end
			end
			default: state_d = sstq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		div_start   = 1'b0;
		ctrl        = '0;
		out_load    = 1'b0;
		res_task    = '0;
		res_valid   = 1'b0;
		res_tick    = '0;
		res_full    = 1'b0;
		res_last    = 1'b1;
		unique case (state_q)
			sstq_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && (mode == sstq_pkg::MODE_SLEEP);
			end
			sstq_pkg::ST_DIV: begin
			end
			sstq_pkg::ST_INS: begin
				if (out_free) begin
					out_load    = 1'b1;
					res_tick    = wake_q;
					res_full    = full;
					ctrl.insert = !full;
				end
			end
			sstq_pkg::ST_TICK: begin
				if (out_free) begin
					out_load = 1'b1;
					if (head_due) begin
						ctrl.pop  = 1'b1;
						res_task  = cells[0].id;
						res_valid = 1'b1;
						res_tick  = cells[0].wake;
						res_last  = !next_due;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sstq_pkg::ST_IDLE;
			period_q    <= sstq_pkg::PERIOD_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (ctrl.insert) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			id_q  <= task_id;
			now_q <= now_tick;
		end
		if (div_done) begin
			wake_q <= now_q + ticks;
		end
		if (out_load) begin
			woken_task_q <= res_task;
			wake_valid_q <= res_valid;
			wake_tick_q  <= res_tick;
			queue_full_q <= res_full;
			last_q       <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign woken_task = woken_task_q;
	assign wake_valid = wake_valid_q;
	assign wake_tick  = wake_tick_q;
	assign queue_full = queue_full_q;
	assign last       = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count beyond depth");

	a_no_insert_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.insert && ctrl.pop))
		else $error("insert and pop in the same cycle");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> (count_q != '0))
		else $error("pop from an empty queue");

	a_insert_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.insert |=> (count_q != '0) && (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the queue");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire

FILE: hw/rtl/sstq_div.sv
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none

module sstq_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sstq_pkg::WAKE_W-1:0]   dividend,
	input  wire logic [sstq_pkg::PERIOD_W-1:0] divisor,
	output logic                              done,
	output logic [sstq_pkg::WAKE_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(sstq_pkg::WAKE_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(sstq_pkg::WAKE_W - 1);

	logic                            busy_q;
	logic                            done_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [sstq_pkg::WAKE_W-1:0]     quo_q;
	logic [sstq_pkg::PERIOD_W-1:0]   rem_q;
	logic [sstq_pkg::PERIOD_W-1:0]   div_q;
	logic [sstq_pkg::PERIOD_W:0]     trial;
	logic [sstq_pkg::PERIOD_W:0]     diff;
	logic                            ge;

	assign trial = {rem_q, quo_q[sstq_pkg::WAKE_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// shift the next dividend bit in, keep the remainder below the divisor
			rem_q <= ge ? diff[sstq_pkg::PERIOD_W-1:0] : trial[sstq_pkg::PERIOD_W-1:0];
			quo_q <= {quo_q[sstq_pkg::WAKE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sstq_cell.sv
// One slot of the sorted queue: holds an entry, shifts right on insert, left on pop.
`default_nettype none

module sstq_cell #(
	parameter int IDX   = 0,
	parameter int DEPTH = sstq_pkg::DEFAULT_DEPTH
) (
	input  wire logic                            clk,
	input  wire sstq_pkg::cell_ctrl_t            ctrl,
	input  wire logic [$clog2(DEPTH+1)-1:0]      count,
	input  wire sstq_pkg::entry_t                new_entry,
	input  wire sstq_pkg::entry_t                left_entry,
	input  wire logic                            left_gt,
	input  wire sstq_pkg::entry_t                right_entry,
	output sstq_pkg::entry_t                     entry,
	output logic                                 gt
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	sstq_pkg::entry_t entry_q;
	logic             occupied;
	logic             at_tail;
	logic             take_new;

	assign occupied = count > IDX_C;
	assign at_tail  = count == IDX_C;
	// strictly later entries move aside, so equal wake ticks keep arrival order
	assign gt       = occupied && (entry_q.wake > new_entry.wake);
	assign take_new = !left_gt && (gt || at_tail);

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= right_entry;
		end else if (ctrl.insert) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (take_new) begin
				entry_q <= new_entry;
			end
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_sleep_timer_queue_core: directed table, then random traffic.

module tb_top;

	localparam int ID_W     = sstq_pkg::ID_W;
	localparam int WAKE_W   = sstq_pkg::WAKE_W;
	localparam int PERIOD_W = sstq_pkg::PERIOD_W;
	localparam logic MODE_SLEEP = sstq_pkg::MODE_SLEEP;
	localparam logic MODE_TICK  = sstq_pkg::MODE_TICK;

	typedef sstq_pkg::entry_t entry_t;

	localparam int QDEPTH      = sstq_pkg::DEFAULT_DEPTH;
	localparam int SETTLE      = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 40;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [ID_W-1:0]   woken_task;
		logic              wake_valid;
		logic [WAKE_W-1:0] wake_tick;
		logic              queue_full;
		logic              last;
	} wake_res_t;

	typedef struct packed {
		logic              mode;
		logic [ID_W-1:0]   task_id;
		logic [WAKE_W-1:0] duration_ms;
		logic [WAKE_W-1:0] now_tick;
	} sleep_req_t;

	typedef enum logic [1:0] {
		ROW_REQ,
		ROW_CHECKED,
		ROW_PERIOD
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		sleep_req_t          req;
		wake_res_t           res;
		logic [PERIOD_W-1:0] period;
	} plan_row_t;

	localparam wake_res_t NONE_DUE = '{'0, 1'b0, '0, 1'b0, 1'b1};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [PERIOD_W-1:0] cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                mode;
	logic [ID_W-1:0]     task_id;
	logic [WAKE_W-1:0]   duration_ms;
	logic [WAKE_W-1:0]   now_tick;
	logic                out_valid;
	logic                out_ready;
	logic [ID_W-1:0]     woken_task;
	logic                wake_valid;
	logic [WAKE_W-1:0]   wake_tick;
	logic                queue_full;
	logic                last;

	// Predicted block state
	entry_t              sleepers[$];
	logic [PERIOD_W-1:0] period_model;

	wake_res_t step_res[$];
	wake_res_t pending_wakes[$];
	plan_row_t plan[$];

	int errors       = 0;
	int results_seen = 0;

	sorted_sleep_timer_queue_core #(
		.QUEUE_DEPTH(QDEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.task_id    (task_id),
		.duration_ms(duration_ms),
		.now_tick   (now_tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.woken_task (woken_task),
		.wake_valid (wake_valid),
		.wake_tick  (wake_tick),
		.queue_full (queue_full),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Work out the results of one request and update the predicted queue.
	function automatic void schedule_step(input sleep_req_t rq);
		logic [WAKE_W-1:0]   ticks;
		logic [WAKE_W-1:0]   wake;
		logic [PERIOD_W-1:0] div;
		int                  pos;
		entry_t              ent;
		step_res.delete();
		if (rq.mode == MODE_SLEEP) begin
			div = (period_model == '0) ? PERIOD_W'(1) : period_model;
			ticks = rq.duration_ms / WAKE_W'(div);
			if (ticks == '0)
				ticks = WAKE_W'(1);
			wake = rq.now_tick + ticks;
			if (sleepers.size() >= QDEPTH) begin
				step_res.push_back('{'0, 1'b0, wake, 1'b1, 1'b1});
			end else begin
				// insert after every entry with an equal or earlier wake tick
				pos = sleepers.size();
				for (int i = 0; i < sleepers.size(); i++) begin
					if (sleepers[i].wake > wake) begin
						pos = i;
						break;
					end
				end
				ent.wake = wake;
				ent.id = rq.task_id;
				sleepers.insert(pos, ent);
				step_res.push_back('{'0, 1'b0, wake, 1'b0, 1'b1});
			end
		end else begin
			while (sleepers.size() != 0 && sleepers[0].wake <= rq.now_tick) begin
				ent = sleepers.pop_front();
				step_res.push_back('{ent.id, 1'b1, ent.wake, 1'b0, 1'b0});
			end
			if (step_res.size() == 0)
				step_res.push_back(NONE_DUE);
			else
				step_res[step_res.size()-1].last = 1'b1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic plan_row_t req_row(input logic m, input logic [ID_W-1:0] id,
			input logic [WAKE_W-1:0] dur, input logic [WAKE_W-1:0] now);
		return '{ROW_REQ, '{m, id, dur, now}, '0, '0};
	endfunction

	function automatic plan_row_t checked_row(input logic m, input logic [ID_W-1:0] id,
			input logic [WAKE_W-1:0] dur, input logic [WAKE_W-1:0] now, input wake_res_t res);
		return '{ROW_CHECKED, '{m, id, dur, now}, res, '0};
	endfunction

	function automatic plan_row_t period_row(input logic [PERIOD_W-1:0] v);
		return '{ROW_PERIOD, '0, '0, v};
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offer one request after a random gap; record its expected results on transfer.
	task automatic offer(input sleep_req_t rq, input bit typed, input wake_res_t typed_res);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= rq.mode;
		task_id     <= rq.task_id;
		duration_ms <= rq.duration_ms;
		now_tick    <= rq.now_tick;
		do @(posedge clk); while (!in_ready);
		schedule_step(rq);
		if (typed)
			pending_wakes.push_back(typed_res);
		else
			foreach (step_res[i]) pending_wakes.push_back(step_res[i]);
	endtask

	// Write the tick period once the block has drained.
	task automatic write_period(input logic [PERIOD_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_wakes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (!in_ready) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		period_model = v;
	endtask

	// Mostly well-formed traffic on an advancing tick, with some fully random noise.
	task automatic run_mixed(input int n, input logic [WAKE_W-1:0] start);
		sleep_req_t        rq;
		logic [WAKE_W-1:0] clock_now;
		clock_now = start;
		repeat (n) begin
			rq.task_id = ID_W'($urandom);
			if ($urandom_range(0, 99) < 15) begin
				rq.mode        = 1'($urandom_range(0, 1));
				rq.duration_ms = $urandom;
				rq.now_tick    = $urandom;
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					rq.mode        = MODE_TICK;
					clock_now      = clock_now + $urandom_range(0, 20);
					rq.duration_ms = $urandom;
				end else begin
					rq.mode        = MODE_SLEEP;
					rq.duration_ms = $urandom_range(0, 20 * int'(period_model) + 20);
				end
				rq.now_tick = clock_now;
			end
			offer(rq, 1'b0, '0);
		end
	endtask

	initial begin
		sleep_req_t        rq;
		logic [WAKE_W-1:0] base;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		mode        <= MODE_SLEEP;
		task_id     <= '0;
		duration_ms <= '0;
		now_tick    <= '0;
		sleepers.delete();
		period_model = sstq_pkg::PERIOD_RESET;

		plan.push_back(checked_row(MODE_TICK, 6'd0, 32'd0, 32'd0, NONE_DUE));
		plan.push_back(checked_row(MODE_TICK, 6'd63, '1, '1, NONE_DUE));
		plan.push_back(checked_row(MODE_SLEEP, 6'd0, 32'd0, 32'd0,
			'{6'd0, 1'b0, 32'd1, 1'b0, 1'b1}));
		plan.push_back(checked_row(MODE_SLEEP, 6'd63, '1, '1,
			'{6'd0, 1'b0, 32'h1999_9998, 1'b0, 1'b1}));
		plan.push_back(checked_row(MODE_SLEEP, 6'd5, 32'd9, 32'd100,
			'{6'd0, 1'b0, 32'd101, 1'b0, 1'b1}));
		// equal wake ticks queue in arrival order; the same id may sleep twice
		plan.push_back(req_row(MODE_SLEEP, 6'd6, 32'd20, 32'd99));
		plan.push_back(req_row(MODE_SLEEP, 6'd5, 32'd30, 32'd98));
		plan.push_back(req_row(MODE_SLEEP, 6'd42, 32'd1000, 32'd0));
		plan.push_back(checked_row(MODE_TICK, 6'd0, 32'd0, 32'd0, NONE_DUE));
		plan.push_back(checked_row(MODE_TICK, 6'd0, 32'd0, 32'd1,
			'{6'd0, 1'b1, 32'd1, 1'b0, 1'b1}));
		plan.push_back(req_row(MODE_TICK, 6'd0, 32'd0, 32'd101));
		plan.push_back(req_row(MODE_SLEEP, 6'd21, 32'hAAAA_AAAA, 32'h5555_5555));
		plan.push_back(req_row(MODE_SLEEP, 6'd42, 32'h5555_5555, 32'hAAAA_AAAA));
		plan.push_back(req_row(MODE_TICK, 6'd0, 32'd0, '1));
		// a zero period divides by one
		plan.push_back(period_row('0));
		plan.push_back(checked_row(MODE_SLEEP, 6'd1, 32'd0, 32'd5,
			'{6'd0, 1'b0, 32'd6, 1'b0, 1'b1}));
		plan.push_back(req_row(MODE_SLEEP, 6'd2, 32'd7, 32'd5));
		plan.push_back(period_row('1));
		plan.push_back(req_row(MODE_SLEEP, 6'd3, 32'd2046, 32'd0));
		plan.push_back(req_row(MODE_SLEEP, 6'd4, 32'd1022, 32'd0));
		plan.push_back(req_row(MODE_TICK, 6'd0, 32'd0, '1));
		plan.push_back(period_row(PERIOD_W'(1)));
		// wake tick wraps past the top of the counter
		plan.push_back(checked_row(MODE_SLEEP, 6'd7, '1, 32'd1,
			'{6'd0, 1'b0, 32'd0, 1'b0, 1'b1}));
		plan.push_back(checked_row(MODE_TICK, 6'd0, 32'd0, 32'd0,
			'{6'd7, 1'b1, 32'd0, 1'b0, 1'b1}));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_PERIOD)
				write_period(plan[i].period);
			else
				offer(plan[i].req, plan[i].kind == ROW_CHECKED, plan[i].res);
		end

		write_period(PERIOD_W'($urandom_range(1, 1000)));
		run_mixed(16, $urandom_range(0, 10000));

		// fill the queue past its depth, then wake everything at once
		write_period(PERIOD_W'($urandom_range(1, 1023)));
		base = $urandom_range(0, 1 << 20);
		repeat (QDEPTH + 2) begin
			rq.mode        = MODE_SLEEP;
			rq.task_id     = ID_W'($urandom);
			rq.duration_ms = $urandom;
			rq.now_tick    = base + $urandom_range(0, 100);
			offer(rq, 1'b0, '0);
		end
		rq.mode        = MODE_TICK;
		rq.task_id     = ID_W'($urandom);
		rq.duration_ms = $urandom;
		rq.now_tick    = '1;
		offer(rq, 1'b0, '0);

		write_period(PERIOD_W'($urandom_range(0, 1023)));
		run_mixed(16, 32'hFFFF_FF00);

		in_valid <= 1'b0;
		while (pending_wakes.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random ready pattern plus one long hold-off to back up the block.
	initial begin
		int run;
		int stall;
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= 40) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		wake_res_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_wakes.size() == 0) begin
				$display("%0t: unexpected result: task %0d valid %0b tick %0h full %0b last %0b",
					$time, woken_task, wake_valid, wake_tick, queue_full, last);
				errors++;
			end else begin
				want = pending_wakes.pop_front();
				check_field("woken_task", 32'(want.woken_task), 32'(woken_task));
				check_field("wake_valid", 32'(want.wake_valid), 32'(wake_valid));
				check_field("wake_tick", want.wake_tick, wake_tick);
				check_field("queue_full", 32'(want.queue_full), 32'(queue_full));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout, %0d results still expected", $time, pending_wakes.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/sstq_pkg.sv
hw/rtl/sstq_div.sv
hw/rtl/sstq_cell.sv
hw/rtl/sorted_sleep_timer_queue_core.sv
tb/tb_top.sv
